// ----- rtl/core/u2tbc_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to Thai broadcast charset package
// Shared types and constants for the decoder front, queue and emitter.
// ----------------------------------------------------------------------------
package u2tbc_pkg;

  localparam logic [7:0] HeaderByte      = 8'h0E;
  localparam logic [7:0] ReplacementByte = 8'h3F;

  // One decoded input transaction: header flag, number of charset bytes
  // (zero, one or two copies of data), end of text and the malformed flag.
  typedef struct packed {
    logic       hdr;
    logic [1:0] cnt;
    logic [7:0] data;
    logic       done;
    logic       malformed;
  } desc_t;

endpackage

// ----- rtl/core/u2tbc_front.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to Thai broadcast charset decoder front
// Accepts text bytes, runs the UTF-8 decoder and produces one descriptor
// per input transaction that yields at least one result.
// ----------------------------------------------------------------------------
module u2tbc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       text_byte_i,
  input  logic             end_of_text_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output u2tbc_pkg::desc_t q_desc_o
);
  import u2tbc_pkg::*;

  logic [20:0] acc_q, acc_d;
  logic [1:0]  rem_q, rem_d;
  logic [1:0]  len_q, len_d;
  logic [7:0]  lead_q, lead_d;
  logic        hdr_sent_q, hdr_sent_d;
  logic        err_q, err_d;

  logic        accept;
  logic        lead_ascii;
  logic [1:0]  lead_len;
  logic [20:0] lead_acc;
  logic        cont;
  logic        second_ok;
  logic        use_lead;
  logic        emit_cp;
  logic [20:0] cp;
  logic [20:0] acc_next;
  logic        err_n;
  logic        mapped;
  logic [7:0]  cp_low;
  logic [1:0]  cnt;
  logic [7:0]  data;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  assign lead_ascii = !text_byte_i[7];
  assign cont       = (text_byte_i[7:6] == 2'b10);
  assign acc_next   = {acc_q[14:0], text_byte_i[5:0]};

  always_comb begin
    lead_len = 2'd0;
    lead_acc = 21'd0;
    if (text_byte_i >= 8'hC2 && text_byte_i <= 8'hDF) begin
      lead_len = 2'd1;
      lead_acc = {16'd0, text_byte_i[4:0]};
    end else if (text_byte_i >= 8'hE0 && text_byte_i <= 8'hEF) begin
      lead_len = 2'd2;
      lead_acc = {17'd0, text_byte_i[3:0]};
    end else if (text_byte_i >= 8'hF0 && text_byte_i <= 8'hF4) begin
      lead_len = 2'd3;
      lead_acc = {18'd0, text_byte_i[2:0]};
    end
  end

  always_comb begin
    unique case (lead_q)
      8'hE0:   second_ok = (text_byte_i >= 8'hA0);
      8'hED:   second_ok = (text_byte_i <= 8'h9F);
      8'hF0:   second_ok = (text_byte_i >= 8'h90);
      8'hF4:   second_ok = (text_byte_i <= 8'h8F);
      default: second_ok = 1'b1;
    endcase
  end

  always_comb begin
    acc_d    = acc_q;
    rem_d    = rem_q;
    len_d    = len_q;
    lead_d   = lead_q;
    err_n    = err_q;
    emit_cp  = 1'b0;
    cp       = 21'd0;
    use_lead = 1'b0;

    if (rem_q != 2'd0) begin
      if (!cont) begin
        err_n    = 1'b1;
        use_lead = 1'b1;
        acc_d    = 21'd0;
        rem_d    = 2'd0;
        len_d    = 2'd0;
        lead_d   = 8'd0;
      end else if (rem_q == len_q && !second_ok) begin
        err_n  = 1'b1;
        acc_d  = 21'd0;
        rem_d  = 2'd0;
        len_d  = 2'd0;
        lead_d = 8'd0;
      end else if (rem_q == 2'd1) begin
        emit_cp = 1'b1;
        cp      = acc_next;
        acc_d   = 21'd0;
        rem_d   = 2'd0;
        len_d   = 2'd0;
        lead_d  = 8'd0;
      end else begin
        acc_d = acc_next;
        rem_d = rem_q - 2'd1;
      end
    end else begin
      use_lead = 1'b1;
    end

    if (use_lead) begin
      if (lead_ascii) begin
        emit_cp = 1'b1;
        cp      = {13'd0, text_byte_i};
      end else if (lead_len != 2'd0) begin
        acc_d  = lead_acc;
        len_d  = lead_len;
        rem_d  = lead_len;
        lead_d = text_byte_i;
      end else begin
        err_n = 1'b1;
      end
    end

    if (end_of_text_i && rem_d != 2'd0) begin
      err_n = 1'b1;
    end

    hdr_sent_d = 1'b1;
    err_d      = err_n;
    if (end_of_text_i) begin
      acc_d      = 21'd0;
      rem_d      = 2'd0;
      len_d      = 2'd0;
      lead_d     = 8'd0;
      hdr_sent_d = 1'b0;
      err_d      = 1'b0;
    end
  end

  assign cp_low = cp[7:0];
  assign mapped = (cp[20:8] == 13'h000E) &&
                  ((cp_low >= 8'h01 && cp_low <= 8'h2E) ||
                   (cp_low >= 8'h30 && cp_low <= 8'h4F) ||
                   (cp_low >= 8'h50 && cp_low <= 8'h5B));

  always_comb begin
    if (!emit_cp) begin
      cnt = 2'd0;
    end else if (cp[20:16] != 5'd0) begin
      cnt = 2'd2;
    end else begin
      cnt = 2'd1;
    end
  end

  assign data = (mapped || cp[20:7] == 14'd0) ? cp_low : ReplacementByte;

  assign q_desc_o = '{hdr: !hdr_sent_q, cnt: cnt, data: data,
                      done: end_of_text_i, malformed: err_n};
  assign q_push_o = accept && (!hdr_sent_q || cnt != 2'd0 || end_of_text_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= 21'd0;
      rem_q      <= 2'd0;
      len_q      <= 2'd0;
      lead_q     <= 8'd0;
      hdr_sent_q <= 1'b0;
      err_q      <= 1'b0;
    end else if (accept) begin
      acc_q      <= acc_d;
      rem_q      <= rem_d;
      len_q      <= len_d;
      lead_q     <= lead_d;
      hdr_sent_q <= hdr_sent_d;
      err_q      <= err_d;
    end
  end

endmodule

// ----- rtl/core/u2tbc_queue.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to Thai broadcast charset descriptor queue
// A small first-in first-out buffer between the decoder and the emitter.
// ----------------------------------------------------------------------------
module u2tbc_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  u2tbc_pkg::desc_t push_desc_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output u2tbc_pkg::desc_t head_o
);
  import u2tbc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/u2tbc_back.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to Thai broadcast charset emitter
// Expands each descriptor into its result transactions and holds them in an
// output register towards the receiver.
// ----------------------------------------------------------------------------
module u2tbc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  u2tbc_pkg::desc_t q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             byte_present_o,
  output logic             text_done_o,
  output logic             malformed_o
);
  import u2tbc_pkg::*;

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       present_q, done_q, mal_q;

  logic       marker;
  logic [1:0] total;
  logic       last_piece;
  logic       load;
  logic [7:0] piece_byte;
  logic       piece_present;

  assign marker     = !q_head_i.hdr && (q_head_i.cnt == 2'd0);
  assign total      = {1'b0, q_head_i.hdr} + q_head_i.cnt + {1'b0, marker};
  assign last_piece = (idx_q == total - 2'd1);
  assign load       = q_valid_i && (!valid_q || !out_stall_i);
  assign q_pop_o    = load && last_piece;

  always_comb begin
    if (q_head_i.hdr && idx_q == 2'd0) begin
      piece_byte    = HeaderByte;
      piece_present = 1'b1;
    end else if (marker) begin
      piece_byte    = 8'd0;
      piece_present = 1'b0;
    end else begin
      piece_byte    = q_head_i.data;
      piece_present = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q    <= piece_byte;
      present_q <= piece_present;
      done_q    <= q_head_i.done && last_piece;
      mal_q     <= q_head_i.malformed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last_piece ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign byte_present_o = present_q;
  assign text_done_o    = done_q;
  assign malformed_o    = mal_q;

endmodule

// ----- rtl/core/utf8_to_thai_broadcast_charset_core.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to Thai broadcast charset converter
// Input channel: in_valid_i / in_stall_o with text_byte_i and end_of_text_i.
// Output channel: out_valid_o / out_stall_i with out_byte_o, byte_present_o,
// text_done_o and malformed_o. A transaction completes on a rising edge with
// valid high and stall low.
// Each text starts with the header byte 0x0E. Every completed code point gives
// one charset byte, or two replacement bytes above U+FFFF. A final byte that
// yields nothing produces an end marker with byte_present_o low.
// Input transactions pass through the descriptor queue to the output register.
// The block takes one byte per cycle while the queue is not full; a byte giving
// several results sends them one at a time, so the rate is set by the single-result output register.
// A descriptor queue of QueueDepth entries separates decoder and emitter, so
// input is taken while the receiver stalls until the queue is full; a stalled
// result holds its payload unchanged.
// Reset clears the decoder, the queue and the output register; the next byte
// begins a new text.
// ----------------------------------------------------------------------------
module utf8_to_thai_broadcast_charset_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_present_o,
  output logic       text_done_o,
  output logic       malformed_o
);
  import u2tbc_pkg::*;

  desc_t push_desc, head_desc;
  logic  q_full, q_push, q_pop, q_valid;

  u2tbc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_desc_o      (push_desc)
  );

  u2tbc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_desc)
  );

  u2tbc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_head_i       (head_desc),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .byte_present_o (byte_present_o),
    .text_done_o    (text_done_o),
    .malformed_o    (malformed_o)
  );

endmodule

// ----- rtl/core/u2tbc_checker.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to Thai broadcast charset port checker
// Observes the ports of the converter and checks text framing over time.
// ----------------------------------------------------------------------------
module u2tbc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       byte_present_o,
  input logic       text_done_o,
  input logic       malformed_o
);
  import u2tbc_pkg::*;

  logic out_acc;
  logic expect_hdr_q;
  logic prev_mal_q;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_hdr_q <= 1'b1;
      prev_mal_q   <= 1'b0;
    end else if (out_acc) begin
      expect_hdr_q <= text_done_o;
      prev_mal_q   <= malformed_o && !text_done_o;
    end
  end

  a_marker_ends_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_present_o |-> text_done_o)
    else $error("end marker without end of text");

  a_header_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && expect_hdr_q |-> byte_present_o && out_byte_o == HeaderByte)
    else $error("text does not start with the header byte");

  a_malformed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !expect_hdr_q && prev_mal_q |-> malformed_o)
    else $error("malformed flag dropped within a text");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled result changed");

endmodule

bind utf8_to_thai_broadcast_charset_core u2tbc_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_byte_o     (out_byte_o),
  .byte_present_o (byte_present_o),
  .text_done_o    (text_done_o),
  .malformed_o    (malformed_o)
);
